/* src/alu_multiply_accumulate_unit_core_macros.svh */
// Assertion macros used by the checker file.
`ifndef ALU_MULTIPLY_ACCUMULATE_UNIT_CORE_MACROS_SVH
`define ALU_MULTIPLY_ACCUMULATE_UNIT_CORE_MACROS_SVH

// Check a same-cycle implication, disabled during reset.
`define AMAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, disabled during reset.
`define AMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/amac_pkg.sv */
package amac_pkg;

    // Operation classes produced by the front end
    typedef enum logic [3:0] {
        OP_ADC   = 4'd0,
        OP_SBC   = 4'd1,
        OP_EXTB  = 4'd2,
        OP_EXTUB = 4'd3,
        OP_EXTH  = 4'd4,
        OP_EXTUH = 4'd5,
        OP_MLTH  = 4'd6,
        OP_MLTUH = 4'd7,
        OP_MLTW  = 4'd8,
        OP_MLTUW = 4'd9,
        OP_MAC   = 4'd10,
        OP_NOP   = 4'd15
    } op_t;

    // Flag bit positions
    localparam int FLAG_C  = 0;
    localparam int FLAG_V  = 1;
    localparam int FLAG_Z  = 2;
    localparam int FLAG_N  = 3;
    localparam int FLAG_MO = 4;

    // Cycle cost codes
    localparam logic [2:0] COST_BASE     = 3'd1;
    localparam logic [2:0] COST_MAC_STEP = 3'd2;
    localparam logic [2:0] COST_MAC_DONE = 3'd4;
    localparam logic [2:0] COST_MUL_WORD = 3'd5;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [3:0]         mode;
        logic [31:0]        first_operand;
        logic [31:0]        second_operand;
        logic [31:0]        mac_count;
        logic [31:0]        addr_a;
        logic [31:0]        addr_b;
        logic signed [15:0] half_a;
        logic signed [15:0] half_b;
    } in_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        write_result;
        logic [4:0]  flag_bits;
        logic [63:0] accumulator;
        logic [31:0] next_count;
        logic [31:0] next_addr_a;
        logic [31:0] next_addr_b;
        logic        repeat_instruction;
        logic [2:0]  cycle_cost;
    } out_t;

    // Classified operation with its product already formed
    typedef struct packed {
        op_t         op;
        logic [31:0] first_operand;
        logic [31:0] second_operand;
        logic [31:0] mac_count;
        logic [31:0] addr_a;
        logic [31:0] addr_b;
        logic [63:0] product;
    } op_item_t;

endpackage

/* src/amac_front.sv */
module amac_front (
    input  logic                in_valid,
    output logic                in_ready,
    input  amac_pkg::in_t       in_item,
    output logic                op_valid,
    input  logic                op_ready,
    output amac_pkg::op_item_t  op_item
);

    amac_pkg::op_t      op;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_full;

    // Classify the mode; codes without meaning become a no-op
    always_comb
    begin
        unique case (in_item.mode) inside
            amac_pkg::OP_ADC, amac_pkg::OP_SBC, amac_pkg::OP_EXTB, amac_pkg::OP_EXTUB,
            amac_pkg::OP_EXTH, amac_pkg::OP_EXTUH, amac_pkg::OP_MLTH, amac_pkg::OP_MLTUH,
            amac_pkg::OP_MLTW, amac_pkg::OP_MLTUW, amac_pkg::OP_MAC:
                op = amac_pkg::op_t'(in_item.mode);
            default:
                op = amac_pkg::OP_NOP;
        endcase
    end

    // Select multiplier operands; one shared signed 33x33 multiplier
    always_comb
    begin
        case (op)
            amac_pkg::OP_MLTH:
            begin
                mul_a = {{17{in_item.first_operand[15]}}, in_item.first_operand[15:0]};
                mul_b = {{17{in_item.second_operand[15]}}, in_item.second_operand[15:0]};
            end
            amac_pkg::OP_MLTUH:
            begin
                mul_a = {17'd0, in_item.first_operand[15:0]};
                mul_b = {17'd0, in_item.second_operand[15:0]};
            end
            amac_pkg::OP_MLTW:
            begin
                mul_a = {in_item.first_operand[31], in_item.first_operand};
                mul_b = {in_item.second_operand[31], in_item.second_operand};
            end
            amac_pkg::OP_MLTUW:
            begin
                mul_a = {1'b0, in_item.first_operand};
                mul_b = {1'b0, in_item.second_operand};
            end
            amac_pkg::OP_MAC:
            begin
                mul_a = {{17{in_item.half_a[15]}}, in_item.half_a};
                mul_b = {{17{in_item.half_b[15]}}, in_item.half_b};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Build the queue entry
    always_comb
    begin
        op_item.op             = op;
        op_item.first_operand  = in_item.first_operand;
        op_item.second_operand = in_item.second_operand;
        op_item.mac_count      = in_item.mac_count;
        op_item.addr_a         = in_item.addr_a;
        op_item.addr_b         = in_item.addr_b;
        op_item.product        = mul_full[63:0];
    end

    assign op_valid = in_valid;
    assign in_ready = op_ready;

endmodule

/* src/amac_queue.sv */
module amac_queue #(
    parameter int DEPTH = amac_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  amac_pkg::op_item_t  push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output amac_pkg::op_item_t  pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    amac_pkg::op_item_t entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/amac_back.sv */
module amac_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_ready,
    input  amac_pkg::op_item_t  op_item,
    output logic                out_valid,
    input  logic                out_ready,
    output amac_pkg::out_t      out_item
);

    logic [63:0]    acc_reg, acc_next;
    logic [4:0]     flags_reg, flags_next;
    logic           out_valid_reg;
    amac_pkg::out_t out_item_reg, out_item_next;
    logic           take;

    logic [31:0] a, b, res;
    logic        cin;
    logic [32:0] add_sum, sub_diff;
    logic [63:0] mac_sum;

    assign op_ready  = !out_valid_reg || out_ready;
    assign take      = op_valid && op_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign a        = op_item.first_operand;
    assign b        = op_item.second_operand;
    assign cin      = flags_reg[amac_pkg::FLAG_C];
    assign add_sum  = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    assign sub_diff = {1'b0, a} - {1'b0, b} - {32'd0, cin};
    assign mac_sum  = acc_reg + op_item.product;

    // Execute one operation against the accumulator and flags
    always_comb
    begin
        res        = '0;
        acc_next   = acc_reg;
        flags_next = flags_reg;
        out_item_next                    = '0;
        out_item_next.cycle_cost         = amac_pkg::COST_BASE;
        unique case (op_item.op) inside
            amac_pkg::OP_ADC:
            begin
                res = add_sum[31:0];
                flags_next[amac_pkg::FLAG_C] = add_sum[32];
                flags_next[amac_pkg::FLAG_V] = ~(a[31] ^ b[31]) & (a[31] ^ res[31]);
                flags_next[amac_pkg::FLAG_Z] = (res == '0);
                flags_next[amac_pkg::FLAG_N] = res[31];
                out_item_next.write_result   = 1'b1;
            end
            amac_pkg::OP_SBC:
            begin
                res = sub_diff[31:0];
                flags_next[amac_pkg::FLAG_C] = sub_diff[32];
                flags_next[amac_pkg::FLAG_V] = (a[31] ^ b[31]) & (a[31] ^ res[31]);
                flags_next[amac_pkg::FLAG_Z] = (res == '0);
                flags_next[amac_pkg::FLAG_N] = res[31];
                out_item_next.write_result   = 1'b1;
            end
            amac_pkg::OP_EXTB:
            begin
                res = {{24{b[7]}}, b[7:0]};
                out_item_next.write_result = 1'b1;
            end
            amac_pkg::OP_EXTUB:
            begin
                res = {24'd0, b[7:0]};
                out_item_next.write_result = 1'b1;
            end
            amac_pkg::OP_EXTH:
            begin
                res = {{16{b[15]}}, b[15:0]};
                out_item_next.write_result = 1'b1;
            end
            amac_pkg::OP_EXTUH:
            begin
                res = {16'd0, b[15:0]};
                out_item_next.write_result = 1'b1;
            end
            amac_pkg::OP_MLTH, amac_pkg::OP_MLTUH:
            begin
                acc_next = {acc_reg[63:32], op_item.product[31:0]};
            end
            amac_pkg::OP_MLTW, amac_pkg::OP_MLTUW:
            begin
                acc_next = op_item.product;
                out_item_next.cycle_cost = amac_pkg::COST_MUL_WORD;
            end
            amac_pkg::OP_MAC:
            begin
                if (op_item.mac_count != '0)
                begin
                    acc_next = mac_sum;
                    // Hold MO sticky; set it on signed overflow of the sum
                    if ((acc_reg[63] == op_item.product[63]) &&
                        (mac_sum[63] != acc_reg[63]))
                    begin
                        flags_next[amac_pkg::FLAG_MO] = 1'b1;
                    end
                    out_item_next.next_count         = op_item.mac_count - 32'd1;
                    out_item_next.next_addr_a        = op_item.addr_a + 32'd2;
                    out_item_next.next_addr_b        = op_item.addr_b + 32'd2;
                    out_item_next.repeat_instruction = 1'b1;
                    out_item_next.cycle_cost         = amac_pkg::COST_MAC_STEP;
                end
                else
                begin
                    out_item_next.next_addr_a = op_item.addr_a;
                    out_item_next.next_addr_b = op_item.addr_b;
                    out_item_next.cycle_cost  = amac_pkg::COST_MAC_DONE;
                end
            end
            default:
            begin
            end
        endcase
        out_item_next.result_value = res;
        out_item_next.flag_bits    = flags_next;
        out_item_next.accumulator  = acc_next;
    end

    // Hold state and the output transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                acc_reg   <= acc_next;
                flags_reg <= flags_next;
            end
            if (op_ready)
            begin
                out_valid_reg <= op_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

/* src/alu_multiply_accumulate_unit_core.sv */
// Execute unit with a 64-bit accumulator and the flags C, V, Z, N and MO.
// Input channel: in_valid / in_ready / in_item, one instruction per
// transaction (mode, operands, mac count and addresses, two halfwords).
// Output channel: out_valid / out_ready / out_item, one result per
// transaction: value for rd and its write enable, flags, accumulator,
// updated mac count and addresses, repeat request and cycle cost.
// The front end decodes the mode and forms any product in the shared
// 33x33 multiplier, then writes a small queue. The back end applies the
// operation to the accumulator and flags and holds the result in an
// output register.
// Each instruction passes through a queue entry and then the output
// register before it is offered on the output channel.
// Throughput: one transaction per cycle while out_ready holds, as the
// back end forms its accumulate and flag update combinationally.
// Reset clears the accumulator, the flags, the queue and the output valid.
// When the receiver stalls, the output register holds its transaction,
// the queue fills (QUEUE_DEPTH entries) and in_ready drops once it is full.
module alu_multiply_accumulate_unit_core #(
    parameter int QUEUE_DEPTH = amac_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  amac_pkg::in_t  in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output amac_pkg::out_t out_item
);

    logic               fq_valid, fq_ready;
    amac_pkg::op_item_t fq_item;
    logic               qb_valid, qb_ready;
    amac_pkg::op_item_t qb_item;

    amac_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .op_valid (fq_valid),
        .op_ready (fq_ready),
        .op_item  (fq_item)
    );

    amac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    amac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (qb_valid),
        .op_ready  (qb_ready),
        .op_item   (qb_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

/* src/amac_checker.sv */
`include "alu_multiply_accumulate_unit_core_macros.svh"

module amac_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_ready,
    input amac_pkg::out_t out_item
);

    // Hold a stalled output transaction
    `AMAC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item), "stalled output changed")

    // MO stays set from one result to the next when they come back to back
    `AMAC_ASSERT_NOW(a_mo_sticky, clk, rst_n, (out_valid && out_ready && out_item.flag_bits[amac_pkg::FLAG_MO]) ##1 out_valid, out_item.flag_bits[amac_pkg::FLAG_MO], "MO flag cleared")

    // Drive a zero value when rd is not written
    `AMAC_ASSERT_NOW(a_no_write_zero, clk, rst_n, out_valid && !out_item.write_result, out_item.result_value == 32'd0, "value without write")

    // A repeat request comes only from a mac step that accumulated
    `AMAC_ASSERT_NOW(a_repeat_cost, clk, rst_n, out_valid && out_item.repeat_instruction, (out_item.cycle_cost == amac_pkg::COST_MAC_STEP) && !out_item.write_result, "bad repeat result")

endmodule

bind alu_multiply_accumulate_unit_core amac_checker u_amac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

/* tb/tb_alu_multiply_accumulate_unit_core.sv */
`timescale 1ns / 100ps

module tb_alu_multiply_accumulate_unit_core;

    localparam int          CLK_HALF       = 4;
    localparam int          RANDOM_ITEMS   = 2000;
    localparam int          CYCLE_LIMIT    = 500000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          PRINT_LIMIT    = 50;
    localparam logic [3:0]  MODE_UNUSED_LO = 4'd11;

    // Predicts each execute result from the instruction stream and holds
    // the results still owed by the block.
    class mac_unit_scoreboard;
        logic [63:0]    acc;
        logic [4:0]     flags;
        amac_pkg::out_t owed_q[$];
        int             mismatches;
        int             checked;
        int             mac_steps;

        function new();
            acc        = '0;
            flags      = '0;
            mismatches = 0;
            checked    = 0;
            mac_steps  = 0;
        endfunction

        // Run one instruction against the local accumulator and flags.
        function amac_pkg::out_t execute(amac_pkg::in_t it);
            amac_pkg::out_t     r;
            logic [32:0]        sum33;
            logic [32:0]        sub33;
            logic [31:0]        res;
            logic [4:0]         f;
            logic               cin;
            logic signed [31:0] prod32;
            logic signed [63:0] prod64;
            logic [63:0]        acc_sum;
            r            = '0;
            r.cycle_cost = amac_pkg::COST_BASE;
            cin          = flags[amac_pkg::FLAG_C];
            f            = '0;
            case (it.mode) inside
                amac_pkg::OP_ADC, amac_pkg::OP_SBC:
                begin
                    if (it.mode == amac_pkg::OP_ADC)
                    begin
                        sum33     = {1'b0, it.first_operand} + {1'b0, it.second_operand}
                                    + {32'b0, cin};
                        res       = sum33[31:0];
                        f[amac_pkg::FLAG_C] = sum33[32];
                        f[amac_pkg::FLAG_V] = ~(it.first_operand[31] ^ it.second_operand[31])
                                              & (it.first_operand[31] ^ res[31]);
                    end
                    else
                    begin
                        res       = it.first_operand - it.second_operand - {31'b0, cin};
                        sub33     = {1'b0, it.second_operand} + {32'b0, cin};
                        f[amac_pkg::FLAG_C] = {1'b0, it.first_operand} < sub33;
                        f[amac_pkg::FLAG_V] = (it.first_operand[31] ^ it.second_operand[31])
                                              & (it.first_operand[31] ^ res[31]);
                    end
                    f[amac_pkg::FLAG_Z]  = (res == 32'd0);
                    f[amac_pkg::FLAG_N]  = res[31];
                    f[amac_pkg::FLAG_MO] = flags[amac_pkg::FLAG_MO];
                    flags          = f;
                    r.result_value = res;
                    r.write_result = 1'b1;
                end
                amac_pkg::OP_EXTB:
                begin
                    r.result_value = {{24{it.second_operand[7]}}, it.second_operand[7:0]};
                    r.write_result = 1'b1;
                end
                amac_pkg::OP_EXTUB:
                begin
                    r.result_value = {24'b0, it.second_operand[7:0]};
                    r.write_result = 1'b1;
                end
                amac_pkg::OP_EXTH:
                begin
                    r.result_value = {{16{it.second_operand[15]}}, it.second_operand[15:0]};
                    r.write_result = 1'b1;
                end
                amac_pkg::OP_EXTUH:
                begin
                    r.result_value = {16'b0, it.second_operand[15:0]};
                    r.write_result = 1'b1;
                end
                amac_pkg::OP_MLTH:
                begin
                    prod32     = $signed(it.first_operand[15:0]) * $signed(it.second_operand[15:0]);
                    acc[31:0]  = prod32;
                end
                amac_pkg::OP_MLTUH:
                begin
                    acc[31:0] = {16'b0, it.first_operand[15:0]} * {16'b0, it.second_operand[15:0]};
                end
                amac_pkg::OP_MLTW:
                begin
                    prod64       = $signed(it.first_operand) * $signed(it.second_operand);
                    acc          = prod64;
                    r.cycle_cost = amac_pkg::COST_MUL_WORD;
                end
                amac_pkg::OP_MLTUW:
                begin
                    acc          = {32'b0, it.first_operand} * {32'b0, it.second_operand};
                    r.cycle_cost = amac_pkg::COST_MUL_WORD;
                end
                amac_pkg::OP_MAC:
                begin
                    if (it.mac_count != 32'd0)
                    begin
                        prod64  = $signed(it.half_a) * $signed(it.half_b);
                        acc_sum = acc + prod64;
                        // sticky overflow: same operand signs, different sum sign
                        if ((acc[63] == prod64[63]) && (acc_sum[63] != acc[63]))
                            flags[amac_pkg::FLAG_MO] = 1'b1;
                        acc                  = acc_sum;
                        r.next_count         = it.mac_count - 32'd1;
                        r.next_addr_a        = it.addr_a + 32'd2;
                        r.next_addr_b        = it.addr_b + 32'd2;
                        r.repeat_instruction = 1'b1;
                        r.cycle_cost         = amac_pkg::COST_MAC_STEP;
                        mac_steps++;
                    end
                    else
                    begin
                        r.next_addr_a = it.addr_a;
                        r.next_addr_b = it.addr_b;
                        r.cycle_cost  = amac_pkg::COST_MAC_DONE;
                    end
                end
                default:
                begin
                end
            endcase
            r.flag_bits   = flags;
            r.accumulator = acc;
            return r;
        endfunction

        function void note_instruction(amac_pkg::in_t it);
            owed_q.push_back(execute(it));
        endfunction

        task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("[%0t] mismatch %0d on %s: expected %h, got %h",
                         $realtime, mismatches, what, want, got);
        endtask

        task check_result(amac_pkg::out_t got);
            amac_pkg::out_t want;
            if (owed_q.size() == 0)
            begin
                report_mismatch("result with nothing owed", '0, got.accumulator);
                return;
            end
            want = owed_q.pop_front();
            checked++;
            if (got.result_value !== want.result_value)
                report_mismatch("result_value", want.result_value, got.result_value);
            if (got.write_result !== want.write_result)
                report_mismatch("write_result", want.write_result, got.write_result);
            if (got.flag_bits !== want.flag_bits)
                report_mismatch("flag_bits", want.flag_bits, got.flag_bits);
            if (got.accumulator !== want.accumulator)
                report_mismatch("accumulator", want.accumulator, got.accumulator);
            if (got.next_count !== want.next_count)
                report_mismatch("next_count", want.next_count, got.next_count);
            if (got.next_addr_a !== want.next_addr_a)
                report_mismatch("next_addr_a", want.next_addr_a, got.next_addr_a);
            if (got.next_addr_b !== want.next_addr_b)
                report_mismatch("next_addr_b", want.next_addr_b, got.next_addr_b);
            if (got.repeat_instruction !== want.repeat_instruction)
                report_mismatch("repeat_instruction", want.repeat_instruction,
                                got.repeat_instruction);
            if (got.cycle_cost !== want.cycle_cost)
                report_mismatch("cycle_cost", want.cycle_cost, got.cycle_cost);
        endtask
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    amac_pkg::in_t  in_item   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    amac_pkg::out_t out_item;

    mac_unit_scoreboard sb = new();

    int items_sent  = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    int calm_left   = 0;
    int cycle_count = 0;

    alu_multiply_accumulate_unit_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #(CLK_HALF) clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count,
                     sb.owed_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sample both channels on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_instruction(in_item);
            if (out_valid && out_ready)
                sb.check_result(out_item);
        end
    end

    // Stall the output in random stretches, with occasional calm windows between.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 3) == 0)
                begin
                    stall_left = $urandom_range(1, 12);
                    if ($urandom_range(0, 9) == 0)
                        calm_left = $urandom_range(50, 300);
                end
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_half();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic amac_pkg::in_t mk(logic [3:0] mode, logic [31:0] a, logic [31:0] b,
                                         logic [31:0] cnt, logic [31:0] pa, logic [31:0] pb,
                                         logic [15:0] ha, logic [15:0] hb);
        amac_pkg::in_t it;
        it.mode           = mode;
        it.first_operand  = a;
        it.second_operand = b;
        it.mac_count      = cnt;
        it.addr_a         = pa;
        it.addr_b         = pb;
        it.half_a         = ha;
        it.half_b         = hb;
        return it;
    endfunction

    function automatic amac_pkg::in_t random_item();
        return mk(4'($urandom_range(0, 15)), pick_word(), pick_word(), pick_word(),
                  pick_word(), pick_word(), pick_half(), pick_half());
    endfunction

    // Drive one transaction; called at a falling edge, returns at one.
    task automatic send_item(amac_pkg::in_t it);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 16);
        end
        burst_left--;
        in_item  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    // Carry, borrow, extensions, multiplies, count-zero mac, unused modes,
    // then a run that overflows the accumulator and sets MO.
    task automatic run_directed();
        send_item(mk(amac_pkg::OP_ADC,   32'h0,         32'h0,         0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_ADC,   32'hFFFF_FFFF, 32'h1,         0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_ADC,   32'h0,         32'h0,         0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_ADC,   32'h7FFF_FFFF, 32'h1,         0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_SBC,   32'h0,         32'h1,         0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_SBC,   32'h5,         32'h3,         0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_SBC,   32'h8000_0000, 32'h1,         0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_EXTB,  32'hFFFF_FFFF, 32'h0000_0080, 0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_EXTB,  32'h0,         32'hFFFF_FF7F, 0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_EXTUB, 32'h0,         32'hFFFF_FF80, 0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_EXTH,  32'h0,         32'h0000_8000, 0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_EXTUH, 32'h0,         32'hFFFF_8000, 0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_MLTH,  32'hABCD_8000, 32'h1234_8000, 0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_MLTH,  32'h0000_FFFF, 32'h0000_0001, 0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_MLTUH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_MLTW,  32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_MLTW,  32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_MLTUW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_MAC, 0, 0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                     16'h8000, 16'h8000));
        send_item(mk(amac_pkg::OP_NOP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        send_item(mk(MODE_UNUSED_LO,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_MLTUW, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0));
        send_item(mk(amac_pkg::OP_MAC, 0, 0, 32'h2, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                     16'h8000, 16'h8000));
        send_item(mk(amac_pkg::OP_MAC, 0, 0, 32'h1, 32'h0000_0001, 32'h0000_0000,
                     16'h8000, 16'h8000));
        send_item(mk(amac_pkg::OP_MAC, 0, 0, 32'h0, 32'h0000_0003, 32'h0000_0002,
                     16'h7FFF, 16'h8000));
    endtask

    // One mac loop: optional preload, then count down to zero, sometimes cut short.
    task automatic send_mac_run();
        logic [31:0] cnt;
        logic [31:0] pa;
        logic [31:0] pb;
        int          n;
        int          cut;
        if ($urandom_range(0, 2) == 0)
            send_item(mk(($urandom_range(0, 1) != 0) ? amac_pkg::OP_MLTUW : amac_pkg::OP_MLTW,
                         pick_word(), pick_word(), $urandom, $urandom, $urandom,
                         16'($urandom), 16'($urandom)));
        n   = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
        cnt = n;
        pa  = pick_word();
        pb  = pick_word();
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : -1;
        for (int k = 0; k <= n; k++)
        begin
            if (k == cut)
            begin
                send_item(random_item());
                break;
            end
            send_item(mk(amac_pkg::OP_MAC, $urandom, $urandom, cnt, pa, pb,
                         pick_half(), pick_half()));
            cnt = cnt - 32'd1;
            pa  = pa + 32'd2;
            pb  = pb + 32'd2;
        end
    endtask

    task automatic run_random();
        int target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) < 6)
                send_mac_run();
            else
                send_item(random_item());
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        run_random();
        in_valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle.
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d instructions, checked %0d results, %0d accumulating mac steps.",
                 items_sent, sb.checked, sb.mac_steps);
        $display("Final flags %b, accumulator %h, %0d mismatches.",
                 sb.flags, sb.acc, sb.mismatches);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/amac_pkg.sv
src/amac_front.sv
src/amac_queue.sv
src/amac_back.sv
src/alu_multiply_accumulate_unit_core.sv
src/amac_checker.sv
tb/tb_alu_multiply_accumulate_unit_core.sv
